>>> rtl/sbpr_pkg.sv
// ----------------------------------------------------------------------------
// sbpr_pkg
// Types and constants shared by the servo bus position read block.
// ----------------------------------------------------------------------------
package sbpr_pkg;

  localparam logic [7:0]  MARK_BYTE     = 8'hFF;
  localparam logic [7:0]  POS_ADDR      = 8'h38;
  localparam logic [7:0]  READ_LEN      = 8'h04;
  localparam logic [7:0]  READ_INSTR    = 8'h02;
  localparam logic [7:0]  READ_COUNT    = 8'h02;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    RK_SEND = 2'd0,
    RK_DONE = 2'd1,
    RK_FAIL = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    FAIL_NONE    = 3'd0,
    FAIL_MARKERS = 3'd1,
    FAIL_ID      = 3'd2,
    FAIL_LENGTH  = 3'd3,
    FAIL_SERVO   = 3'd4,
    FAIL_TIMEOUT = 3'd5
  } fail_code_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] target_servo;
    logic [7:0] line_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  send_byte;
    logic        final_byte;
    logic [15:0] position_value;
    logic [2:0]  fail_code;
    logic [7:0]  servo_error_bits;
  } out_item_t;

  // Event handed from the parser to the transmit/output stage.
  typedef struct packed {
    logic      load;
    logic      pkt;
    logic [7:0] id;
    out_item_t item;
  } evt_t;

endpackage

>>> rtl/sbpr_parser.sv
// ----------------------------------------------------------------------------
// sbpr_parser
// Input register, timeout register and response parser state machine.
// ----------------------------------------------------------------------------
module sbpr_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbpr_pkg::in_item_t in_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data,
  output sbpr_pkg::evt_t    evt,
  input  logic              evt_ready
);

  logic                 in_vld_r;
  sbpr_pkg::in_item_t   in_r;
  logic [15:0]          timeout_r;

  sbpr_pkg::phase_t     phase_r, phase_nxt;
  logic [1:0]           hdr_cnt_r, hdr_cnt_nxt;
  sbpr_pkg::fail_code_t fault_r, fault_nxt;
  logic [7:0]           exp_id_r, exp_id_nxt;
  logic [7:0]           len_r, len_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic [7:0]           status_r, status_nxt;
  logic [7:0]           pos_lo_r, pos_lo_nxt;
  logic [7:0]           pos_hi_r, pos_hi_nxt;
  logic [15:0]          elapsed_r, elapsed_nxt;

  sbpr_pkg::fail_code_t hdr_fail;
  sbpr_pkg::fail_code_t fault_eff;
  logic [16:0]          tick_sum;
  logic                 advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld_r && (!evt.load || evt_ready);
  assign in_ready  = !in_vld_r || advance;
  assign tick_sum  = {1'b0, elapsed_r} + 17'd1;

  always_comb begin
    hdr_fail = sbpr_pkg::FAIL_NONE;
    if (hdr_cnt_r <= 2'd1) begin
      if (in_r.line_byte != sbpr_pkg::MARK_BYTE) hdr_fail = sbpr_pkg::FAIL_MARKERS;
    end else if (hdr_cnt_r == 2'd2) begin
      if (in_r.line_byte != exp_id_r) hdr_fail = sbpr_pkg::FAIL_ID;
    end else begin
      if (in_r.line_byte < sbpr_pkg::READ_LEN) hdr_fail = sbpr_pkg::FAIL_LENGTH;
    end
    fault_eff = (fault_r == sbpr_pkg::FAIL_NONE) ? hdr_fail : fault_r;
  end

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    fault_nxt   = fault_r;
    exp_id_nxt  = exp_id_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    pos_lo_nxt  = pos_lo_r;
    pos_hi_nxt  = pos_hi_r;
    elapsed_nxt = elapsed_r;
    evt         = '0;
    if (in_vld_r) begin
      case (in_r.operation)
        sbpr_pkg::OP_START: begin
          phase_nxt   = sbpr_pkg::PH_HEADER;
          hdr_cnt_nxt = 2'd0;
          fault_nxt   = sbpr_pkg::FAIL_NONE;
          exp_id_nxt  = in_r.target_servo;
          len_nxt     = 8'd0;
          cnt_nxt     = 8'd0;
          status_nxt  = 8'd0;
          pos_lo_nxt  = 8'd0;
          pos_hi_nxt  = 8'd0;
          elapsed_nxt = 16'd0;
          evt.load    = 1'b1;
          evt.pkt     = 1'b1;
          evt.id      = in_r.target_servo;
        end
        sbpr_pkg::OP_BYTE: begin
          unique case (phase_r)
            sbpr_pkg::PH_HEADER: begin
              fault_nxt = fault_eff;
              if (hdr_cnt_r != 2'd3) begin
                hdr_cnt_nxt = hdr_cnt_r + 2'd1;
              end else begin
                hdr_cnt_nxt = 2'd0;
                if (fault_eff != sbpr_pkg::FAIL_NONE) begin
                  phase_nxt               = sbpr_pkg::PH_IDLE;
                  evt.load                = 1'b1;
                  evt.item.result_kind    = sbpr_pkg::RK_FAIL;
                  evt.item.fail_code      = fault_eff;
                end else begin
                  len_nxt     = in_r.line_byte;
                  cnt_nxt     = 8'd0;
                  elapsed_nxt = 16'd0;
                  phase_nxt   = sbpr_pkg::PH_PAYLOAD;
                end
              end
            end
            sbpr_pkg::PH_PAYLOAD: begin
              if (cnt_r == 8'd0) begin
                status_nxt = in_r.line_byte;
              end else if (cnt_r == 8'd1) begin
                pos_lo_nxt = in_r.line_byte;
              end else if (cnt_r == 8'd2) begin
                pos_hi_nxt = in_r.line_byte;
              end
              cnt_nxt = cnt_r + 8'd1;
              if (cnt_nxt == len_r) begin
                phase_nxt = sbpr_pkg::PH_IDLE;
                evt.load  = 1'b1;
                if (status_nxt != 8'd0) begin
                  evt.item.result_kind      = sbpr_pkg::RK_FAIL;
                  evt.item.fail_code        = sbpr_pkg::FAIL_SERVO;
                  evt.item.servo_error_bits = status_nxt;
                end else begin
                  evt.item.result_kind    = sbpr_pkg::RK_DONE;
                  evt.item.position_value = {pos_hi_nxt, pos_lo_nxt};
                end
              end
            end
            sbpr_pkg::PH_IDLE: begin
            end
            default: begin
            end
          endcase
        end
        sbpr_pkg::OP_TICK: begin
          if (phase_r != sbpr_pkg::PH_IDLE) begin
            elapsed_nxt = tick_sum[15:0];
            if (tick_sum > {1'b0, timeout_r}) begin
              phase_nxt            = sbpr_pkg::PH_IDLE;
              evt.load             = 1'b1;
              evt.item.result_kind = sbpr_pkg::RK_FAIL;
              evt.item.fail_code   = sbpr_pkg::FAIL_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      timeout_r <= sbpr_pkg::TIMEOUT_RESET;
      phase_r   <= sbpr_pkg::PH_IDLE;
      hdr_cnt_r <= 2'd0;
      fault_r   <= sbpr_pkg::FAIL_NONE;
      exp_id_r  <= 8'd0;
      len_r     <= 8'd0;
      cnt_r     <= 8'd0;
      status_r  <= 8'd0;
      pos_lo_r  <= 8'd0;
      pos_hi_r  <= 8'd0;
      elapsed_r <= 16'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        phase_r   <= phase_nxt;
        hdr_cnt_r <= hdr_cnt_nxt;
        fault_r   <= fault_nxt;
        exp_id_r  <= exp_id_nxt;
        len_r     <= len_nxt;
        cnt_r     <= cnt_nxt;
        status_r  <= status_nxt;
        pos_lo_r  <= pos_lo_nxt;
        pos_hi_r  <= pos_hi_nxt;
        elapsed_r <= elapsed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_item;
    end
  end

endmodule

>>> rtl/sbpr_tx.sv
// ----------------------------------------------------------------------------
// sbpr_tx
// Result register and command packet sequencer driving the result channel.
// ----------------------------------------------------------------------------
module sbpr_tx (
  input  logic                clk,
  input  logic                rst_n,
  input  sbpr_pkg::evt_t      evt,
  output logic                evt_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sbpr_pkg::out_item_t out_item
);

  logic                busy_r;
  logic                pkt_r;
  logic [2:0]          idx_r;
  logic [7:0]          id_r;
  sbpr_pkg::out_item_t item_r;
  logic                last_beat;
  logic [7:0]          pkt_byte;

  assign last_beat = !pkt_r || (idx_r == 3'd7);
  assign evt_ready = !busy_r || (out_ready && last_beat);
  assign out_valid = busy_r;

  always_comb begin
    case (idx_r)
      3'd0, 3'd1: pkt_byte = sbpr_pkg::MARK_BYTE;
      3'd2:       pkt_byte = id_r;
      3'd3:       pkt_byte = sbpr_pkg::READ_LEN;
      3'd4:       pkt_byte = sbpr_pkg::READ_INSTR;
      3'd5:       pkt_byte = sbpr_pkg::POS_ADDR;
      3'd6:       pkt_byte = sbpr_pkg::READ_COUNT;
      default:    pkt_byte = ~(id_r + sbpr_pkg::READ_LEN + sbpr_pkg::READ_INSTR
                               + sbpr_pkg::POS_ADDR + sbpr_pkg::READ_COUNT);
    endcase
  end

  always_comb begin
    out_item = item_r;
    if (pkt_r) begin
      out_item             = '0;
      out_item.result_kind = sbpr_pkg::RK_SEND;
      out_item.send_byte   = pkt_byte;
      out_item.final_byte  = (idx_r == 3'd7);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pkt_r  <= 1'b0;
      idx_r  <= 3'd0;
    end else if (evt.load && evt_ready) begin
      busy_r <= 1'b1;
      pkt_r  <= evt.pkt;
      idx_r  <= 3'd0;
    end else if (busy_r && out_ready) begin
      if (last_beat) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.load && evt_ready) begin
      id_r   <= evt.id;
      item_r <= evt.item;
    end
  end

endmodule

>>> rtl/servo_bus_position_read_top.sv
// ----------------------------------------------------------------------------
// servo_bus_position_read_top
// Master side of a half-duplex servo bus read of the position register.
// ----------------------------------------------------------------------------
// Each accepted item passes an input register and the parser, and its result
// goes to the result register, so byte and tick items are taken one per cycle
// unless a result is held up. A read request produces eight command bytes
// from the packet sequencer, one per cycle while out_ready is high; the input
// register holds the next item that has a result until the last of them has
// been transferred, while items without a result keep flowing.
module servo_bus_position_read_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbpr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sbpr_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  sbpr_pkg::evt_t evt;
  logic           evt_ready;

  sbpr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .evt       (evt),
    .evt_ready (evt_ready)
  );

  sbpr_tx u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .evt_ready (evt_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> rtl/sbpr_checker.sv
// ----------------------------------------------------------------------------
// sbpr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sbpr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input sbpr_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_pkt_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_item.result_kind == sbpr_pkg::RK_SEND
      && !out_item.final_byte |=> out_valid)
    else $error("command packet interrupted");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind != sbpr_pkg::RK_SEND
      |-> out_item.send_byte == 8'd0 && !out_item.final_byte)
    else $error("status result carries packet fields");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind == sbpr_pkg::RK_DONE
      |-> out_item.fail_code == sbpr_pkg::FAIL_NONE
          && out_item.servo_error_bits == 8'd0)
    else $error("finished read reports a failure");

endmodule

bind servo_bus_position_read_top sbpr_checker u_sbpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the servo bus position read block. A short table of
// directed items walks the idle, abort, header fault, timeout and extreme
// cases, then random read exchanges run under several timeout settings with
// random idling on both channels. Every result transfer is compared field by
// field against a table expectation or a cycle-free read protocol tracker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbpr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    bit          is_cfg;
    logic [15:0] cfg_value;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [15:0] cfg_data;

  out_item_t awaited_results [$];
  out_item_t step_results [$];
  dir_row_t  dir_rows [$];
  int        mismatches = 0;
  int        live_items = 0;
  int        hold_asked = 0;
  int        hold_served = 0;
  bit        sender_idles = 1'b1;
  bit        calm = 1'b0;

  phase_t      rd_phase = PH_IDLE;
  logic [1:0]  hdr_count = '0;
  fail_code_t  hdr_fault = FAIL_NONE;
  logic [7:0]  want_id = '0;
  logic [7:0]  pay_len = '0;
  logic [7:0]  pay_count = '0;
  logic [7:0]  status_seen = '0;
  logic [7:0]  pos_lo = '0;
  logic [7:0]  pos_hi = '0;
  logic [15:0] tick_count = '0;
  logic [15:0] tick_limit = TIMEOUT_RESET;

  servo_bus_position_read_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void predict_read_step(in_item_t it);
    out_item_t  r;
    logic [7:0] sum;
    logic [7:0] pkt [8];
    logic [16:0] nxt;
    fail_code_t f;
    step_results.delete();
    r = '0;
    case (it.operation)
      OP_START: begin
        sum = it.target_servo + READ_LEN + READ_INSTR + POS_ADDR + READ_COUNT;
        pkt = '{MARK_BYTE, MARK_BYTE, it.target_servo, READ_LEN, READ_INSTR, POS_ADDR,
                READ_COUNT, ~sum};
        for (int i = 0; i < 8; i++) begin
          r.result_kind = RK_SEND;
          r.send_byte = pkt[i];
          r.final_byte = (i == 7);
          step_results.push_back(r);
        end
        rd_phase = PH_HEADER;
        hdr_count = '0;
        hdr_fault = FAIL_NONE;
        want_id = it.target_servo;
        pay_len = '0;
        pay_count = '0;
        status_seen = '0;
        pos_lo = '0;
        pos_hi = '0;
        tick_count = '0;
      end
      OP_BYTE: begin
        if (rd_phase == PH_HEADER) begin
          f = FAIL_NONE;
          if (hdr_count <= 2'd1) begin
            if (it.line_byte != MARK_BYTE) f = FAIL_MARKERS;
          end else if (hdr_count == 2'd2) begin
            if (it.line_byte != want_id) f = FAIL_ID;
          end else if (it.line_byte < READ_LEN) begin
            f = FAIL_LENGTH;
          end
          if (hdr_fault == FAIL_NONE) hdr_fault = f;
          if (hdr_count < 2'd3) begin
            hdr_count++;
          end else begin
            hdr_count = '0;
            if (hdr_fault != FAIL_NONE) begin
              r.result_kind = RK_FAIL;
              r.fail_code = hdr_fault;
              step_results.push_back(r);
              rd_phase = PH_IDLE;
            end else begin
              pay_len = it.line_byte;
              pay_count = '0;
              tick_count = '0;
              rd_phase = PH_PAYLOAD;
            end
          end
        end else if (rd_phase == PH_PAYLOAD) begin
          case (pay_count)
            8'd0: status_seen = it.line_byte;
            8'd1: pos_lo = it.line_byte;
            8'd2: pos_hi = it.line_byte;
            default: ;
          endcase
          pay_count++;
          if (pay_count == pay_len) begin
            rd_phase = PH_IDLE;
            if (status_seen != 8'h00) begin
              r.result_kind = RK_FAIL;
              r.fail_code = FAIL_SERVO;
              r.servo_error_bits = status_seen;
            end else begin
              r.result_kind = RK_DONE;
              r.position_value = {pos_hi, pos_lo};
            end
            step_results.push_back(r);
          end
        end
      end
      OP_TICK: begin
        if (rd_phase != PH_IDLE) begin
          nxt = {1'b0, tick_count} + 17'd1;
          tick_count = nxt[15:0];
          if (nxt > {1'b0, tick_limit}) begin
            rd_phase = PH_IDLE;
            r.result_kind = RK_FAIL;
            r.fail_code = FAIL_TIMEOUT;
            step_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    want = awaited_results.pop_front();
    if (got.result_kind !== want.result_kind)
      report_mismatch($sformatf("result_kind got %0d want %0d", got.result_kind,
                                want.result_kind));
    if (got.send_byte !== want.send_byte)
      report_mismatch($sformatf("send_byte got %h want %h", got.send_byte, want.send_byte));
    if (got.final_byte !== want.final_byte)
      report_mismatch($sformatf("final_byte got %b want %b", got.final_byte,
                                want.final_byte));
    if (got.position_value !== want.position_value)
      report_mismatch($sformatf("position_value got %h want %h", got.position_value,
                                want.position_value));
    if (got.fail_code !== want.fail_code)
      report_mismatch($sformatf("fail_code got %0d want %0d", got.fail_code,
                                want.fail_code));
    if (got.servo_error_bits !== want.servo_error_bits)
      report_mismatch($sformatf("servo_error_bits got %h want %h", got.servo_error_bits,
                                want.servo_error_bits));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_item);
  end

  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    int n;
    if (sender_idles && !calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      @(negedge clk) in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    if (it.operation == OP_START ||
        ((it.operation == OP_BYTE || it.operation == OP_TICK) && rd_phase != PH_IDLE))
      live_items++;
    predict_read_step(it);
    if (typed) awaited_results.push_back(want);
    else foreach (step_results[i]) awaited_results.push_back(step_results[i]);
  endtask

  task automatic send_start(logic [7:0] id);
    in_item_t it;
    it.operation = OP_START;
    it.target_servo = id;
    it.line_byte = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_line(logic [7:0] b);
    in_item_t it;
    it.operation = OP_BYTE;
    it.target_servo = 8'($urandom);
    it.line_byte = b;
    send_item(it);
  endtask

  task automatic send_ticks(int n);
    in_item_t it;
    repeat (n) begin
      it.operation = OP_TICK;
      it.target_servo = 8'($urandom);
      it.line_byte = 8'($urandom);
      send_item(it);
    end
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(0, 9) == 0) send_ticks($urandom_range(1, 3));
  endtask

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tick_limit = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic random_exchange();
    int         form;
    int         spot;
    int         len;
    logic [7:0] id;
    logic [7:0] hdr [4];
    form = $urandom_range(0, 99);
    id = rnd_byte();
    send_start(id);
    hdr[0] = MARK_BYTE;
    hdr[1] = MARK_BYTE;
    hdr[2] = id;
    hdr[3] = 8'($urandom_range(4, 7));
    if (form < 10) begin
      repeat ($urandom_range(0, 5)) send_line(rnd_byte());
    end else if (form < 22) begin
      spot = $urandom_range(0, 3);
      case (spot)
        0, 1: hdr[spot] = 8'($urandom_range(0, 254));
        2: hdr[2] = id ^ 8'($urandom_range(1, 255));
        default: hdr[3] = 8'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 2) == 0) hdr[3] = 8'($urandom_range(0, 3));
      for (int i = 0; i < 4; i++) begin
        maybe_ticks();
        send_line(hdr[i]);
      end
    end else if (form < 30 && tick_limit <= 16'd8) begin
      send_line(MARK_BYTE);
      send_ticks(int'(tick_limit) + 1);
    end else begin
      if ($urandom_range(0, 24) == 0) hdr[3] = 8'($urandom_range(8, 31));
      for (int i = 0; i < 4; i++) begin
        maybe_ticks();
        send_line(hdr[i]);
      end
      len = hdr[3];
      for (int i = 0; i < len; i++) begin
        maybe_ticks();
        if (i == 0) send_line(($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
        else send_line(rnd_byte());
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1) == 0) send_line(rnd_byte());
        else send_ticks(1);
      end
    end
  endtask

  function automatic dir_row_t plain_row(logic [1:0] op, logic [7:0] id, logic [7:0] data);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.cfg_value = '0;
    r.item.operation = op;
    r.item.target_servo = id;
    r.item.line_byte = data;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t limit_row(logic [15:0] value);
    dir_row_t r;
    r = plain_row(OP_TICK, 8'h00, 8'h00);
    r.is_cfg = 1'b1;
    r.cfg_value = value;
    return r;
  endfunction

  function automatic dir_row_t result_row(logic [1:0] op, logic [7:0] data,
                                          result_kind_t kind, fail_code_t code,
                                          logic [7:0] bits, logic [15:0] pos);
    dir_row_t r;
    r = plain_row(op, 8'h5A, data);
    r.typed = 1'b1;
    r.want.result_kind = kind;
    r.want.fail_code = code;
    r.want.servo_error_bits = bits;
    r.want.position_value = pos;
    return r;
  endfunction

  initial begin : receiver
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    dir_rows.push_back(limit_row(16'h0000));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, 8'h00));
    dir_rows.push_back(plain_row(OP_TICK, 8'h00, 8'h00));
    dir_rows.push_back(plain_row(OP_UNUSED, 8'hFF, 8'hFF));
    dir_rows.push_back(plain_row(OP_START, 8'hFF, 8'h00));
    dir_rows.push_back(result_row(OP_TICK, 8'h00, RK_FAIL, FAIL_TIMEOUT, 8'h00, 16'h0000));
    dir_rows.push_back(limit_row(TIMEOUT_RESET));
    dir_rows.push_back(plain_row(OP_START, 8'h00, 8'hFF));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, MARK_BYTE));
    dir_rows.push_back(plain_row(OP_START, 8'h01, 8'h00));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, 8'hFE));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, MARK_BYTE));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, 8'h01));
    dir_rows.push_back(result_row(OP_BYTE, READ_LEN, RK_FAIL, FAIL_MARKERS, 8'h00, 16'h0000));
    dir_rows.push_back(plain_row(OP_START, 8'h02, 8'h00));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, MARK_BYTE));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, MARK_BYTE));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, 8'h03));
    dir_rows.push_back(result_row(OP_BYTE, 8'h03, RK_FAIL, FAIL_ID, 8'h00, 16'h0000));
    dir_rows.push_back(plain_row(OP_START, 8'h7E, 8'h00));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, MARK_BYTE));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, MARK_BYTE));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, 8'h7E));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, READ_LEN));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, 8'h00));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, 8'hFF));
    dir_rows.push_back(plain_row(OP_BYTE, 8'h00, 8'hFF));
    dir_rows.push_back(result_row(OP_BYTE, 8'h00, RK_DONE, FAIL_NONE, 8'h00, 16'hFFFF));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_timeout(dir_rows[i].cfg_value);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    target = live_items + 15;
    while (live_items < target) random_exchange();
    hold_asked++;
    repeat (4) send_start(rnd_byte());
    send_line(MARK_BYTE);
    target = live_items + 35;
    while (live_items < target) random_exchange();

    write_timeout(16'd2);
    target = live_items + 25;
    while (live_items < target) random_exchange();

    write_timeout(16'd1);
    target = live_items + 20;
    while (live_items < target) random_exchange();

    write_timeout(16'hFFFF);
    sender_idles = 1'b0;
    send_start(rnd_byte());
    send_ticks(3);
    sender_idles = 1'b1;
    target = live_items + 15;
    while (live_items < target) random_exchange();

    write_timeout(TIMEOUT_RESET);
    calm = 1'b1;
    target = live_items + 30;
    while (live_items < target) random_exchange();

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
